>>> rtl/assert_macros.svh
// Assertion macros for the RTL, included by hsv_to_rgb_converter.
// No dependencies; clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, spelled as an antecedent and a consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hsvrgb_pkg.sv
// Types and constants for the HSV to RGB converter.
// No dependencies; used by hsvrgb_chan and hsv_to_rgb_converter.
package hsvrgb_pkg;

    // Fixed point: hue is Q0.F, saturation and brightness are Q1.F
    localparam int FRAC_BITS = 16;
    localparam int HUE_W     = FRAC_BITS;
    localparam int SV_W      = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * FRAC_BITS + 2;
    localparam int CHAN_W    = 8;

    localparam logic [SV_W-1:0]   ONE_Q   = SV_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] ONE_SQ  = PROD_W'(1) << (2 * FRAC_BITS);
    localparam logic [PROD_W-1:0] HALF_Q  = PROD_W'(1) << (FRAC_BITS - 1);

    // Hue sector, six per turn
    typedef enum logic [2:0] {
        SECT_0 = 3'd0,
        SECT_1 = 3'd1,
        SECT_2 = 3'd2,
        SECT_3 = 3'd3,
        SECT_4 = 3'd4,
        SECT_5 = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SV_W-1:0]  saturation;
        logic [SV_W-1:0]  brightness;
    } hsv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

endpackage

>>> rtl/hsvrgb_chan.sv
// One output channel: brightness times factor, then scale by 255 and round.
// Depends on hsvrgb_pkg.
module hsvrgb_chan
    import hsvrgb_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SV_W-1:0]   brightness,
    input  logic [SV_W-1:0]   factor,
    output logic [CHAN_W-1:0] chan
);

    localparam int SCL_W = PROD_W + 8;

    logic [PROD_W-1:0] x_reg;
    logic [PROD_W-1:0] x_next;
    logic [SCL_W-1:0]  scaled;

    // Product stage: v * k, at most ONE*ONE
    assign x_next = PROD_W'(brightness) * PROD_W'(factor);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
        end
    end

    // 255*x + ONE*ONE/2, keep the integer part
    assign scaled = (SCL_W'(x_reg) << 8) - SCL_W'(x_reg) + (SCL_W'(ONE_SQ) >> 1);
    assign chan   = scaled[2*FRAC_BITS +: CHAN_W];

endmodule

>>> rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter, top level: five-stage pipeline with valid/stall channels.
// Depends on hsvrgb_pkg, hsvrgb_chan and assert_macros.svh.
//
// Usage:
//   Input channel hsv (hsv_valid, hsv_stall, hsv): hue, saturation, brightness.
//   Output channel rgb (rgb_valid, rgb_stall, rgb): red, green, blue.
//   An item moves at a rising edge where valid is high and stall is low.
//   Throughput: one item per clock while rgb_stall stays low.
//   Stages: five register stages (clamp/sector, f*s products, factor
//   rounding, brightness products, scale/select into the output register).
//   Stalls: each stage loads when it is empty or its successor moves, so
//   bubbles close up; hsv_stall rises only when all five stages hold items
//   and rgb_stall is high. A stalled rgb holds its value.
//   Reset: rst_n clears every valid bit; the pipeline starts empty.
//   Saturation and brightness above 1.0 are clamped to 1.0; hue wraps.
`include "assert_macros.svh"

module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic hsv_valid,
    output logic hsv_stall,
    input  hsv_t hsv,
    output logic rgb_valid,
    input  logic rgb_stall,
    output rgb_t rgb
);

    localparam int H6_W = HUE_W + 3;
    localparam int FS_W = PROD_W;

    // Stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ld1, ld2, ld3, ld4, ld5;

    // Stage 1: clamped inputs, sector and fraction
    logic [SV_W-1:0]  s1_sat_reg, s1_sat_next;
    logic [SV_W-1:0]  s1_bri_reg, s1_bri_next;
    sector_t          s1_sec_reg, s1_sec_next;
    logic [HUE_W-1:0] s1_f_reg, s1_f_next;
    logic [H6_W-1:0]  h6;

    // Stage 2: f*s and (1-f)*s
    logic [FS_W-1:0]  s2_fs_reg, s2_fs_next;
    logic [FS_W-1:0]  s2_gs_reg, s2_gs_next;
    logic [SV_W-1:0]  s2_sat_reg;
    logic [SV_W-1:0]  s2_bri_reg;
    sector_t          s2_sec_reg;

    // Stage 3: rounded factors
    logic [SV_W-1:0]  s3_kp_reg, s3_kp_next;
    logic [SV_W-1:0]  s3_kq_reg, s3_kq_next;
    logic [SV_W-1:0]  s3_kt_reg, s3_kt_next;
    logic [FS_W-1:0]  kq_wide, kt_wide;
    logic [SV_W-1:0]  s3_bri_reg;
    sector_t          s3_sec_reg;

    // Stage 4 lives in the channel units; sector rides alongside
    sector_t          s4_sec_reg;
    logic [CHAN_W-1:0] cv, cp, cq, ct;

    // Stage 5: output register
    rgb_t rgb_reg, rgb_next;

    // Load when empty or when the next stage moves
    assign ld5 = !v5_reg || !rgb_stall;
    assign ld4 = !v4_reg || ld5;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;

    assign hsv_stall = !ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= hsv_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: clamp, 6*hue = 4*hue + 2*hue
    always_comb
    begin
        s1_sat_next = (hsv.saturation > ONE_Q) ? ONE_Q : hsv.saturation;
        s1_bri_next = (hsv.brightness > ONE_Q) ? ONE_Q : hsv.brightness;
        h6          = (H6_W'(hsv.hue) << 2) + (H6_W'(hsv.hue) << 1);
        s1_sec_next = sector_t'(h6[H6_W-1 -: 3]);
        s1_f_next   = h6[HUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_sat_reg <= s1_sat_next;
            s1_bri_reg <= s1_bri_next;
            s1_sec_reg <= s1_sec_next;
            s1_f_reg   <= s1_f_next;
        end
    end

    // Stage 2: the two hue-dependent products
    assign s2_fs_next = FS_W'(s1_f_reg) * FS_W'(s1_sat_reg);
    assign s2_gs_next = FS_W'(ONE_Q - SV_W'(s1_f_reg)) * FS_W'(s1_sat_reg);

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_fs_reg  <= s2_fs_next;
            s2_gs_reg  <= s2_gs_next;
            s2_sat_reg <= s1_sat_reg;
            s2_bri_reg <= s1_bri_reg;
            s2_sec_reg <= s1_sec_reg;
        end
    end

    // Stage 3: kq, kt = ONE*ONE - product, rounded half up to Q1.F; kp = ONE - s
    always_comb
    begin
        kq_wide    = (ONE_SQ - s2_fs_reg + HALF_Q) >> FRAC_BITS;
        kt_wide    = (ONE_SQ - s2_gs_reg + HALF_Q) >> FRAC_BITS;
        s3_kq_next = kq_wide[SV_W-1:0];
        s3_kt_next = kt_wide[SV_W-1:0];
        s3_kp_next = ONE_Q - s2_sat_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_kp_reg  <= s3_kp_next;
            s3_kq_reg  <= s3_kq_next;
            s3_kt_reg  <= s3_kt_next;
            s3_bri_reg <= s2_bri_reg;
            s3_sec_reg <= s2_sec_reg;
        end
    end

    // Stage 4: brightness products, one unit per candidate channel
    hsvrgb_chan u_chan_v (
        .clk        (clk),
        .en         (ld4),
        .brightness (s3_bri_reg),
        .factor     (ONE_Q),
        .chan       (cv)
    );

    hsvrgb_chan u_chan_p (
        .clk        (clk),
        .en         (ld4),
        .brightness (s3_bri_reg),
        .factor     (s3_kp_reg),
        .chan       (cp)
    );

    hsvrgb_chan u_chan_q (
        .clk        (clk),
        .en         (ld4),
        .brightness (s3_bri_reg),
        .factor     (s3_kq_reg),
        .chan       (cq)
    );

    hsvrgb_chan u_chan_t (
        .clk        (clk),
        .en         (ld4),
        .brightness (s3_bri_reg),
        .factor     (s3_kt_reg),
        .chan       (ct)
    );

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            s4_sec_reg <= s3_sec_reg;
        end
    end

    // Stage 5: route channels by sector
    always_comb
    begin
        case (s4_sec_reg)
            SECT_0:
            begin
                rgb_next.red = cv; rgb_next.green = ct; rgb_next.blue = cp;
            end
            SECT_1:
            begin
                rgb_next.red = cq; rgb_next.green = cv; rgb_next.blue = cp;
            end
            SECT_2:
            begin
                rgb_next.red = cp; rgb_next.green = cv; rgb_next.blue = ct;
            end
            SECT_3:
            begin
                rgb_next.red = cp; rgb_next.green = cq; rgb_next.blue = cv;
            end
            SECT_4:
            begin
                rgb_next.red = ct; rgb_next.green = cp; rgb_next.blue = cv;
            end
            default:
            begin
                rgb_next.red = cv; rgb_next.green = cp; rgb_next.blue = cq;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb_valid = v5_reg;
    assign rgb       = rgb_reg;

    // Checks
    `ASSERT_CLK(a_stall_full, hsv_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg), "input stalled with an empty stage")
    `ASSERT_CLK(a_rise_src, $rose(rgb_valid) |-> $past(v4_reg), "result appeared without a stage 4 item")
    `ASSERT_NEXT(a_factor_max, v3_reg, 1'b1 && ($past(s3_kq_reg) <= ONE_Q) && ($past(s3_kt_reg) <= ONE_Q) && ($past(s3_kp_reg) <= ONE_Q), "rounded factor above one")

endmodule

>>> dv/tb.sv
// Testbench for hsv_to_rgb_converter: directed corners and sector edges, random colors.
// Depends on hsvrgb_pkg and the converter RTL; predicts each color from its own model.
`timescale 1ns / 100ps

module tb;
    import hsvrgb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [63:0] ONE_W = 64'd1 << FRAC_BITS;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic hsv_valid = 1'b0;
    logic hsv_stall;
    hsv_t hsv = '0;
    logic rgb_valid;
    logic rgb_stall = 1'b0;
    rgb_t rgb;

    rgb_t expected_rgb[$];
    int   mismatches = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    hsv_to_rgb_converter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb)
    );

    always #5 clk = ~clk;

    // Run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Scale brightness by factor k (Q1.2F) to an 8-bit channel, rounding half up twice
    function automatic logic [7:0] scale_channel(logic [16:0] v, logic [63:0] k);
        logic [63:0] kr;
        logic [63:0] x;
        logic [63:0] c;
        kr = (k + (ONE_W >> 1)) >> FRAC_BITS;
        x  = {47'd0, v} * kr;
        c  = (64'd255 * x + ((ONE_W * ONE_W) >> 1)) >> (2 * FRAC_BITS);
        return c[7:0];
    endfunction

    // Expected color for one HSV item
    function automatic rgb_t rgb_of_hsv(hsv_t c);
        logic [16:0] s;
        logic [16:0] v;
        logic [63:0] h6;
        logic [63:0] f;
        logic [63:0] one2;
        logic [7:0]  cv, cp, cq, ct;
        sector_t     sect;
        rgb_t        o;
        s = (c.saturation > ONE_Q) ? ONE_Q : c.saturation;
        v = (c.brightness > ONE_Q) ? ONE_Q : c.brightness;
        h6 = {48'd0, c.hue} * 64'd6;
        sect = sector_t'(h6[FRAC_BITS +: 3]);
        f = h6 & (ONE_W - 1);
        one2 = ONE_W * ONE_W;
        cv = scale_channel(v, one2);
        cp = scale_channel(v, ONE_W * (ONE_W - {47'd0, s}));
        cq = scale_channel(v, one2 - f * {47'd0, s});
        ct = scale_channel(v, one2 - (ONE_W - f) * {47'd0, s});
        case (sect)
            SECT_0:  o = '{red: cv, green: ct, blue: cp};
            SECT_1:  o = '{red: cq, green: cv, blue: cp};
            SECT_2:  o = '{red: cp, green: cv, blue: ct};
            SECT_3:  o = '{red: cp, green: cq, blue: cv};
            SECT_4:  o = '{red: ct, green: cp, blue: cv};
            default: o = '{red: cv, green: cp, blue: cq};
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Receiver: random stall, driven at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
            rgb_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare every accepted color with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rgb_valid && !rgb_stall)
        begin
            if (expected_rgb.size() == 0)
                report_mismatch("unexpected item, red", rgb.red, -1);
            else
            begin
                rgb_t want;
                want = expected_rgb.pop_front();
                if (rgb.red !== want.red)
                    report_mismatch("red", rgb.red, want.red);
                if (rgb.green !== want.green)
                    report_mismatch("green", rgb.green, want.green);
                if (rgb.blue !== want.blue)
                    report_mismatch("blue", rgb.blue, want.blue);
            end
        end
    end

    // Offer one item, with random idle cycles ahead; returns after it is accepted
    task automatic send_hsv(logic [15:0] h, logic [16:0] s, logic [16:0] v);
        hsv_t item;
        logic stalled;
        item = '{hue: h, saturation: s, brightness: v};
        while ($urandom_range(99) < send_idle_pct)
        begin
            hsv_valid <= 1'b0;
            @(posedge clk);
        end
        hsv_valid <= 1'b1;
        hsv <= item;
        forever
        begin
            @(negedge clk);
            stalled = hsv_stall;
            @(posedge clk);
            if (!stalled)
                break;
        end
        expected_rgb.push_back(rgb_of_hsv(item));
    endtask

    // Saturation or brightness level: mostly in range, some above one
    function automatic logic [16:0] rand_level();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 17'd0;
        else if (sel == 1)
            return ONE_Q;
        else if (sel < 8)
            return 17'($urandom_range(65536));
        else
            return 17'($urandom_range(131071));
    endfunction

    // Extremes of every field, clamping and rounding corners
    task automatic test_corners();
        send_hsv(16'd0, 17'd0, 17'd0);
        send_hsv(16'hFFFF, ONE_Q, ONE_Q);
        send_hsv(16'd0, ONE_Q, ONE_Q);
        send_hsv(16'd12345, 17'd0, ONE_Q);
        send_hsv(16'd40000, ONE_Q, 17'd0);
        send_hsv(16'd1, 17'd1, 17'd1);
        send_hsv(16'd30000, 17'd32768, 17'd32768);
        // saturation and brightness above one clamp to one
        send_hsv(16'd20000, 17'd65537, ONE_Q);
        send_hsv(16'd50000, ONE_Q, 17'd65537);
        send_hsv(16'h5555, 17'h1FFFF, 17'h1FFFF);
        send_hsv(16'hAAAA, 17'h1FFFF, 17'd100);
        send_hsv(16'd7000, 17'h0FFFF, 17'h0FFFF);
    endtask

    // Both sides of each sector boundary within the turn, where f wraps
    task automatic test_sector_boundaries();
        int b;
        for (int k = 1; k < 6; k++)
        begin
            b = (k * 65536 + 5) / 6;
            send_hsv(16'(b - 1), ONE_Q, ONE_Q);
            send_hsv(16'(b), ONE_Q, 17'd50000);
        end
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        logic [15:0] h;
        int b;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                // near a sector edge
                b = ($urandom_range(1, 5) * 65536 + 5) / 6;
                h = 16'(b + $urandom_range(4) - 2);
            end
            else
                h = 16'($urandom_range(65535));
            send_hsv(h, rand_level(), rand_level());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_stall_pct = 55;
        test_corners();
        test_sector_boundaries();
        test_random(500, 24, 55);
        test_random(500, 55, 24);
        test_random(500, 0, 0);

        hsv_valid <= 1'b0;
        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
